/* hw/rtl/msc_pkg.sv */
// Shared types and codes for the mutation set subset check.
// Used by msc_ctrl, msc_dp and mutation_set_subset_check; depends on nothing.
package msc_pkg;

    localparam int MODE_W  = 2;
    localparam int KEY_W   = 32;
    localparam int DATE_W  = 21;
    localparam int DIST_W  = 9;
    localparam int ORDER_W = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD_SRC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_TGT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPARE  = 2'd2;

    localparam logic [ORDER_W-1:0] ORDER_EARLIER = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_LATER   = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load_src;  // append key to source list
        logic load_tgt;  // append key to target list
        logic start;     // capture dates, rewind scan pointers
        logic check;     // decide trivial cases from counts
        logic step;      // compare one source/target pair
        logic finish;    // load result register, clear lists
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic no_scan;   // result known from counts alone
        logic scan_end;  // current compare ends the scan
    } sts_t;

endpackage

/* hw/rtl/msc_ctrl.sv */
// Controller state machine for the mutation set subset check.
// Depends on msc_pkg; drives msc_dp through cmd_t and reads sts_t.
module msc_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [msc_pkg::MODE_W-1:0]  mode,
    output logic                        out_valid,
    input  logic                        out_ready,
    output msc_pkg::cmd_t               cmd,
    input  msc_pkg::sts_t               sts
);
    import msc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_src = (mode == MODE_LOAD_SRC);
                    cmd.load_tgt = (mode == MODE_LOAD_TGT);
                    if (mode == MODE_COMPARE)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                cmd.check  = 1'b1;
                state_next = sts.no_scan ? S_DONE : S_RD;
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.step   = 1'b1;
                state_next = sts.scan_end ? S_DONE : S_RD;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a new result only appears out of the done state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside done state");

    // memory read is always followed by its compare
    a_read_then_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |=> (state_reg == S_CMP))
        else $error("read cycle not followed by compare");

    // finishing never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result overwritten");

endmodule

/* hw/rtl/msc_dp.sv */
// Datapath for the mutation set subset check: key stores, counts, scan pointers,
// result register. Depends on msc_pkg; controlled by msc_ctrl.
module msc_dp #(
    parameter int MAX_MUTS = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  msc_pkg::cmd_t                cmd,
    output msc_pkg::sts_t                sts,
    input  logic [msc_pkg::KEY_W-1:0]    mutation_key,
    input  logic [msc_pkg::DATE_W-1:0]   source_date,
    input  logic [msc_pkg::DATE_W-1:0]   target_date,
    output logic                         is_subset,
    output logic [msc_pkg::DIST_W-1:0]   distance,
    output logic [msc_pkg::ORDER_W-1:0]  time_order,
    output logic                         overflow
);
    import msc_pkg::*;

    localparam int CW = $clog2(MAX_MUTS + 1);
    localparam int AW = (MAX_MUTS > 1) ? $clog2(MAX_MUTS) : 1;
    localparam logic [CW-1:0] FULL = CW'(MAX_MUTS);

    logic [KEY_W-1:0]  src_mem [MAX_MUTS];
    logic [KEY_W-1:0]  tgt_mem [MAX_MUTS];
    logic [KEY_W-1:0]  src_q, tgt_q;

    logic [CW-1:0]     scnt_reg, scnt_next;
    logic [CW-1:0]     tcnt_reg, tcnt_next;
    logic              lost_reg, lost_next;
    logic [CW-1:0]     si_reg, si_next;
    logic [CW-1:0]     ti_reg, ti_next;
    logic              sub_reg, sub_next;
    logic [DATE_W-1:0] sdate_reg, tdate_reg;

    logic              src_full, tgt_full;
    logic              hit, si_last, ti_last;
    logic [CW-1:0]     diff;
    logic [ORDER_W-1:0] order;

    logic              is_subset_reg;
    logic [DIST_W-1:0] distance_reg;
    logic [ORDER_W-1:0] time_order_reg;
    logic              overflow_reg;

    assign src_full = (scnt_reg == FULL);
    assign tgt_full = (tcnt_reg == FULL);

    // stores: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (cmd.load_src && !src_full)
            src_mem[scnt_reg[AW-1:0]] <= mutation_key;
        if (cmd.load_tgt && !tgt_full)
            tgt_mem[tcnt_reg[AW-1:0]] <= mutation_key;
        src_q <= src_mem[si_reg[AW-1:0]];
        tgt_q <= tgt_mem[ti_reg[AW-1:0]];
    end

    assign hit     = (src_q == tgt_q);
    assign si_last = ((si_reg + CW'(1)) == scnt_reg);
    assign ti_last = ((ti_reg + CW'(1)) == tcnt_reg);

    assign sts.no_scan  = (scnt_reg >= tcnt_reg) || (scnt_reg == '0);
    assign sts.scan_end = (hit && si_last) || ti_last;

    assign diff = tcnt_reg - scnt_reg;

    always_comb
    begin
        if (sdate_reg < tdate_reg)
            order = ORDER_EARLIER;
        else if (sdate_reg > tdate_reg)
            order = ORDER_LATER;
        else
            order = ORDER_EQUAL;
    end

    always_comb
    begin
        scnt_next = scnt_reg;
        tcnt_next = tcnt_reg;
        lost_next = lost_reg;
        si_next   = si_reg;
        ti_next   = ti_reg;
        sub_next  = sub_reg;

        if (cmd.load_src)
        begin
            if (src_full)
                lost_next = 1'b1;
            else
                scnt_next = scnt_reg + CW'(1);
        end
        if (cmd.load_tgt)
        begin
            if (tgt_full)
                lost_next = 1'b1;
            else
                tcnt_next = tcnt_reg + CW'(1);
        end
        if (cmd.start)
        begin
            si_next = '0;
            ti_next = '0;
        end
        if (cmd.check)
            sub_next = (scnt_reg < tcnt_reg);   // empty source passes if the target is not empty
        if (cmd.step)
        begin
            // greedy scan: target always advances, source only on a match
            ti_next = ti_reg + CW'(1);
            if (hit)
                si_next = si_reg + CW'(1);
            if (sts.scan_end)
                sub_next = hit && si_last;
        end
        if (cmd.finish)
        begin
            scnt_next = '0;
            tcnt_next = '0;
            lost_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scnt_reg <= '0;
            tcnt_reg <= '0;
            lost_reg <= 1'b0;
        end
        else
        begin
            scnt_reg <= scnt_next;
            tcnt_reg <= tcnt_next;
            lost_reg <= lost_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg  <= si_next;
        ti_reg  <= ti_next;
        sub_reg <= sub_next;
        if (cmd.start)
        begin
            sdate_reg <= source_date;
            tdate_reg <= target_date;
        end
        if (cmd.finish)
        begin
            is_subset_reg  <= sub_reg;
            distance_reg   <= sub_reg ? DIST_W'(diff) : '0;
            time_order_reg <= order;
            overflow_reg   <= lost_reg;
        end
    end

    assign is_subset  = is_subset_reg;
    assign distance   = distance_reg;
    assign time_order = time_order_reg;
    assign overflow   = overflow_reg;

    // counts never pass the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (scnt_reg <= FULL) && (tcnt_reg <= FULL))
        else $error("list count beyond store depth");

    // every compared pair lies inside the written entries
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (si_reg < scnt_reg) && (ti_reg < tcnt_reg))
        else $error("scan pointer outside list");

    // lists are empty right after a result is taken in
    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (scnt_reg == '0) && (tcnt_reg == '0) && !lost_reg)
        else $error("lists not cleared after compare");

endmodule

/* hw/rtl/mutation_set_subset_check.sv */
// A key load is taken in the idle state, and the block stays ready for the next item.
// A compare passes the check state, then a read and a compare state for each of k target
// keys scanned (k <= MAX_MUTS), then the done state, which waits for a free result slot.
// One item at a time; loads proceed while a result waits to be taken.
// Reset (rst_n, async, active low) empties both lists and clears the flag of lost keys.
// Top level of the mutation set subset check; depends on msc_pkg, msc_ctrl, msc_dp.
module mutation_set_subset_check #(
    parameter int MAX_MUTS = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [msc_pkg::MODE_W-1:0]   mode,
    input  logic [msc_pkg::KEY_W-1:0]    mutation_key,
    input  logic [msc_pkg::DATE_W-1:0]   source_date,
    input  logic [msc_pkg::DATE_W-1:0]   target_date,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         is_subset,
    output logic [msc_pkg::DIST_W-1:0]   distance,
    output logic [msc_pkg::ORDER_W-1:0]  time_order,
    output logic                         overflow
);
    import msc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    msc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    msc_dp #(
        .MAX_MUTS (MAX_MUTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .mutation_key (mutation_key),
        .source_date  (source_date),
        .target_date  (target_date),
        .is_subset    (is_subset),
        .distance     (distance),
        .time_order   (time_order),
        .overflow     (overflow)
    );

endmodule

/* test/msc_checker.sv */
// Checker for the mutation set subset check: tracks both key lists, predicts each result
// and compares it with the block's output. Depends on msc_pkg.
module msc_checker #(
    parameter int MAX_MUTS = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [msc_pkg::MODE_W-1:0]   mode,
    input  logic [msc_pkg::KEY_W-1:0]    mutation_key,
    input  logic [msc_pkg::DATE_W-1:0]   source_date,
    input  logic [msc_pkg::DATE_W-1:0]   target_date,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         is_subset,
    input  logic [msc_pkg::DIST_W-1:0]   distance,
    input  logic [msc_pkg::ORDER_W-1:0]  time_order,
    input  logic                         overflow,
    output int                           fail_count,
    output int                           pending
);
    import msc_pkg::*;

    typedef struct packed {
        logic               subset;
        logic [DIST_W-1:0]  span;
        logic [ORDER_W-1:0] order;
        logic               lost;
    } verdict_t;

    logic [KEY_W-1:0] src_list [MAX_MUTS];
    logic [KEY_W-1:0] tgt_list [MAX_MUTS];
    int               src_len;
    int               tgt_len;
    logic             keys_lost;
    verdict_t         verdict_q [$];

    // greedy forward scan, each search resumes just past the previous hit
    function automatic logic ordered_subset();
        int ti;
        bit found;
        ti = 0;
        if (src_len >= tgt_len)
            return 1'b0;
        for (int si = 0; si < src_len; si++)
        begin
            found = 1'b0;
            while (ti < tgt_len && !found)
            begin
                found = (tgt_list[ti] == src_list[si]);
                ti++;
            end
            if (!found)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic verdict_t judge(logic [DATE_W-1:0] sd, logic [DATE_W-1:0] td);
        verdict_t v;
        v.subset = ordered_subset();
        v.span   = v.subset ? DIST_W'(tgt_len - src_len) : '0;
        if (sd < td)
            v.order = ORDER_EARLIER;
        else if (sd > td)
            v.order = ORDER_LATER;
        else
            v.order = ORDER_EQUAL;
        v.lost = keys_lost;
        return v;
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            src_len    = 0;
            tgt_len    = 0;
            keys_lost  = 1'b0;
            fail_count = 0;
            pending    = 0;
            verdict_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                case (mode)
                    MODE_LOAD_SRC:
                    begin
                        if (src_len < MAX_MUTS)
                        begin
                            src_list[src_len] = mutation_key;
                            src_len++;
                        end
                        else
                            keys_lost = 1'b1;
                    end
                    MODE_LOAD_TGT:
                    begin
                        if (tgt_len < MAX_MUTS)
                        begin
                            tgt_list[tgt_len] = mutation_key;
                            tgt_len++;
                        end
                        else
                            keys_lost = 1'b1;
                    end
                    MODE_COMPARE:
                    begin
                        verdict_q.push_back(judge(source_date, target_date));
                        src_len   = 0;
                        tgt_len   = 0;
                        keys_lost = 1'b0;
                    end
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, %s %0d distance %0d",
                             $time, "actual subset", is_subset, distance);
                    fail_count++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    check_field("is_subset", 32'(want.subset), 32'(is_subset));
                    check_field("distance", 32'(want.span), 32'(distance));
                    check_field("time_order", 32'(want.order), 32'(time_order));
                    check_field("overflow", 32'(want.lost), 32'(overflow));
                end
            end
            pending = verdict_q.size();
        end
    end

endmodule

/* test/tb_mutation_set_subset_check.sv */
// Testbench top for the mutation set subset check: drives key loads and compares,
// shapes ready/valid idling and gives the verdict. Depends on msc_pkg and msc_checker.
module tb_mutation_set_subset_check;
    import msc_pkg::*;

    localparam int MAX_MUTS     = 256;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_TARGET  = 850;
    localparam int QUIET_ITEMS  = 120;
    localparam int LONG_HOLD    = 600;
    localparam int DRAIN_CYCLES = 600;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic [MODE_W-1:0]   mode         = MODE_LOAD_SRC;
    logic [KEY_W-1:0]    mutation_key = '0;
    logic [DATE_W-1:0]   source_date  = '0;
    logic [DATE_W-1:0]   target_date  = '0;
    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic                is_subset;
    logic [DIST_W-1:0]   distance;
    logic [ORDER_W-1:0]  time_order;
    logic                overflow;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int items_sent  = 0;
    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;
    bit hold_req    = 1'b0;

    logic [KEY_W-1:0] src_pick [$];
    logic [KEY_W-1:0] tgt_pick [$];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    mutation_set_subset_check #(
        .MAX_MUTS (MAX_MUTS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .mutation_key (mutation_key),
        .source_date  (source_date),
        .target_date  (target_date),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .is_subset    (is_subset),
        .distance     (distance),
        .time_order   (time_order),
        .overflow     (overflow)
    );

    msc_checker #(
        .MAX_MUTS (MAX_MUTS)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .mutation_key (mutation_key),
        .source_date  (source_date),
        .target_date  (target_date),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .is_subset    (is_subset),
        .distance     (distance),
        .time_order   (time_order),
        .overflow     (overflow),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: short random stalls, one long hold on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else if (!rx_quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_item(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
                             logic [DATE_W-1:0] sd = '0, logic [DATE_W-1:0] td = '0);
        int gap;
        if (!tx_quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        mode         <= m;
        mutation_key <= k;
        source_date  <= sd;
        target_date  <= td;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (m != MODE_UNUSED)
            items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // loads both picked lists in random interleaving, then compares and clears them
    task automatic run_case(logic [DATE_W-1:0] sd, logic [DATE_W-1:0] td);
        int si;
        int ti;
        si = 0;
        ti = 0;
        while (si < src_pick.size() || ti < tgt_pick.size())
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(MODE_UNUSED, $urandom, DATE_W'($urandom), DATE_W'($urandom));
            if (ti >= tgt_pick.size() || (si < src_pick.size() && $urandom_range(0, 1) == 1))
            begin
                send_item(MODE_LOAD_SRC, src_pick[si]);
                si++;
            end
            else
            begin
                send_item(MODE_LOAD_TGT, tgt_pick[ti]);
                ti++;
            end
        end
        send_item(MODE_COMPARE, $urandom, sd, td);
        src_pick.delete();
        tgt_pick.delete();
    endtask

    function automatic logic [DATE_W-1:0] rand_date();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return DATE_W'($urandom);
        endcase
    endfunction

    task automatic run_dated();
        logic [DATE_W-1:0] sd;
        sd = rand_date();
        run_case(sd, ($urandom_range(0, 3) == 0) ? sd : rand_date());
    endtask

    // small lists from a few keys so hits and duplicates are common
    task automatic small_case();
        logic [KEY_W-1:0] pool [4];
        int n_tgt;
        int n_src;
        foreach (pool[i])
            pool[i] = $urandom;
        n_tgt = $urandom_range(0, 8);
        repeat (n_tgt)
            tgt_pick.push_back(pool[$urandom_range(0, 3)]);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                foreach (tgt_pick[i])
                    if ($urandom_range(0, 1) == 1)
                        src_pick.push_back(tgt_pick[i]);
                if (src_pick.size() > 0 && $urandom_range(0, 3) == 0)
                    src_pick[$urandom_range(0, src_pick.size() - 1)] = $urandom;
            end
            6, 7:
                src_pick = tgt_pick;
            default:
            begin
                n_src = $urandom_range(0, 5);
                repeat (n_src)
                    src_pick.push_back(pool[$urandom_range(0, 3)]);
            end
        endcase
        run_dated();
    endtask

    initial
    begin
        bit did_hold;
        bit did_deep;
        bit did_src_full;
        bit did_drain;
        did_hold     = 1'b0;
        did_deep     = 1'b0;
        did_src_full = 1'b0;
        did_drain    = 1'b0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // both lists empty
        run_case('0, '0);
        // empty source against one key
        tgt_pick = '{32'hFFFF_FFFF};
        run_case('0, '1);
        src_pick = '{32'h0000_0000};
        tgt_pick = '{32'h0000_0000, 32'hFFFF_FFFF};
        run_case('1, '0);
        // keys present but out of order
        src_pick = '{32'd5, 32'd7};
        tgt_pick = '{32'd7, 32'd5, 32'd9};
        run_case(21'h0AAAAA, 21'h155555);
        send_item(MODE_UNUSED, 32'hAAAA_AAAA, '1, '1);
        src_pick = '{32'hAAAA_AAAA};
        tgt_pick = '{32'h5555_5555, 32'hAAAA_AAAA};
        run_case(21'h155555, 21'h0AAAAA);
        // equal lengths never count as subset
        src_pick = '{32'd1, 32'd2};
        tgt_pick = '{32'd1, 32'd2};
        run_case(21'h000123, 21'h000123);
        src_pick = '{32'd3, 32'd3};
        tgt_pick = '{32'd3, 32'd4, 32'd3};
        run_case(21'h1FFFFE, 21'h1FFFFF);
        wait_drained();

        while (items_sent < ITEM_TARGET)
        begin
            if (!did_hold && items_sent >= 150)
            begin
                // results back up, second compare must stall the input
                did_hold = 1'b1;
                hold_req = 1'b1;
                tx_quiet = 1'b1;
                small_case();
                small_case();
                small_case();
                tx_quiet = 1'b0;
            end
            else if (!did_deep && items_sent >= 250)
            begin
                // target overfills, empty source gives the widest distance
                did_deep = 1'b1;
                repeat (MAX_MUTS + 2)
                    tgt_pick.push_back($urandom);
                run_dated();
            end
            else if (!did_src_full && items_sent >= 450)
            begin
                did_src_full = 1'b1;
                repeat (MAX_MUTS + 1)
                    src_pick.push_back($urandom);
                repeat (3)
                    tgt_pick.push_back($urandom);
                run_dated();
            end
            else if (!did_drain && items_sent >= 650)
            begin
                did_drain = 1'b1;
                wait_drained();
            end
            else
                small_case();
            if (items_sent >= ITEM_TARGET - QUIET_ITEMS)
            begin
                tx_quiet = 1'b1;
                rx_quiet = 1'b1;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
